// ===== rtl/assert_macros.svh =====
// Assertion helpers for the matrix inverse block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked on every clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/gjinv_pkg.sv =====
package gjinv_pkg;

    localparam int MAX_DIM = 8;
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int SIZE_W = 4;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    localparam logic [0:0] REG_SIZE = 1'b0;
    localparam logic [0:0] REG_EPS  = 1'b1;

    typedef struct packed {
        logic [2:0]         elem_row;
        logic [2:0]         elem_col;
        logic signed [31:0] elem_value;
        logic               last_element;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [31:0] out_value;
        logic               singular;
        logic               last_result;
    } out_item_t;

    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [31:0] quo;
    } div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        if (v > 65'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -65'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== rtl/gjinv_ram.sv =====
module gjinv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/gjinv_div.sv =====
// Restoring divider: (num * 2^16) / den, truncated toward zero, saturated.
module gjinv_div import gjinv_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [47:0] dvd_reg, dvd_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic signed [31:0] quo_reg, quo_next;

    logic [32:0] shifted;
    logic [33:0] trial;
    logic [48:0] qsigned;
    logic [31:0] num_mag;
    logic [31:0] den_mag;

    always_comb begin
        num_mag = req.num[31] ? 32'(-req.num) : req.num;
        den_mag = req.den[31] ? 32'(-req.den) : req.den;
        shifted = {rem_reg[31:0], dvd_reg[47]};
        trial = {1'b0, shifted} - {2'b00, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        neg_next = neg_reg;
        quo_next = quo_reg;
        qsigned = '0;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next = 6'd48;
            dvd_next = {num_mag, 16'h0000};
            rem_next = '0;
            dvs_next = den_mag;
            neg_next = req.num[31] ^ req.den[31];
        end else if (busy_reg) begin
            // one quotient bit per cycle, quotient shifts into dividend low end
            if (!trial[33]) begin
                rem_next = trial[32:0];
                dvd_next = {dvd_reg[46:0], 1'b1};
            end else begin
                rem_next = shifted;
                dvd_next = {dvd_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                qsigned = neg_reg ? 49'(-{1'b0, dvd_next}) : {1'b0, dvd_next};
                quo_next = sat32(65'(signed'(qsigned)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo = quo_reg;

endmodule

// ===== rtl/gjinv_mac.sv =====
// Multiply-subtract: a - trunc(f*b / 2^16), saturated. Product and a are registered; the subtract is combinational.
module gjinv_mac import gjinv_pkg::*; (
    input  logic               aclk,
    input  logic signed [31:0] a_in,
    input  logic signed [31:0] f_in,
    input  logic signed [31:0] b_in,
    output logic signed [31:0] res
);

    logic signed [63:0] prod_reg;
    logic signed [31:0] a_reg;
    logic signed [63:0] adj;
    logic signed [47:0] m;

    always_ff @(posedge aclk) begin
        prod_reg <= f_in * b_in;
        a_reg <= a_in;
    end

    always_comb begin
        // bias negatives so the shift truncates toward zero
        adj = prod_reg[63] ? prod_reg + 64'sd65535 : prod_reg;
        m = adj[63:16];
    end

    assign res = sat32(65'(a_reg) - 65'(m));

endmodule

// ===== rtl/gauss_jordan_matrix_inverse.sv =====
// Matrix inverse by Gauss-Jordan elimination in Q16.16, one element per transfer.
// Load: elements are accepted in the load state. After the last element all 64 entries are copied,
// then per column a pivot scan over the rows, a swap element by element, 2n divisions on the shared
// bit-serial divider, a factor fetch per row and an update of each element of each row cleared.
// Results are read one at a time from the single read port and each is held until m_ready takes it.
// Reset (aresetn low, synchronous): size 8, epsilon 0, idle; matrix memories are not cleared.
module gauss_jordan_matrix_inverse import gjinv_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "assert_macros.svh"

    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_INIT  = 4'd1;
    localparam logic [3:0] ST_SCAN  = 4'd2;
    localparam logic [3:0] ST_SWAP  = 4'd3;
    localparam logic [3:0] ST_PIV   = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_FACT  = 4'd6;
    localparam logic [3:0] ST_ELIM  = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;
    localparam logic [3:0] ST_WAIT  = 4'd9;

    // state, and sub-step counter (ph) within one element operation
    logic [3:0]  st_reg, st_next;
    logic [2:0]  ph_reg, ph_next;
    logic [3:0]  n_reg;
    logic [15:0] eps_reg;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] r_reg, r_next;
    logic [IDX_W-1:0] c_reg, c_next;
    logic [IDX_W-1:0] prow_reg, prow_next;
    logic        side_reg, side_next;
    logic signed [31:0] piv_reg, piv_next;
    logic signed [31:0] fac_reg, fac_next;
    logic signed [31:0] t_reg, t_next;
    logic signed [31:0] u_reg, u_next;
    logic        sing_reg, sing_next;
    logic        mv_reg, mv_next;
    out_item_t   md_reg, md_next;

    // matrix memories: w is the working copy (copied from the load store), v the companion
    logic        w_we, v_we;
    logic [ADDR_W-1:0] w_wa, w_ra, v_wa, v_ra;
    logic [31:0] w_wd, v_wd, w_rd, v_rd;
    logic [31:0] w_rd_s, v_rd_s;
    logic [IDX_W-1:0] nm1;
    logic [ADDR_W:0] init_cnt;

    div_req_t dreq;
    div_rsp_t drsp;
    logic signed [31:0] mac_a, mac_b, mac_res;
    logic signed [31:0] sel_rd;
    logic [32:0] mag_v;
    logic cfg_wr;

    // load store for the incoming matrix: inversion runs on a separate store
    logic        l_we;
    logic [31:0] l_rd;
    logic [ADDR_W-1:0] l_ra;

    gjinv_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_load (
        .aclk(aclk), .we(l_we),
        .waddr({s_data.elem_row, s_data.elem_col}),
        .wdata(s_data.elem_value), .raddr(l_ra), .rdata(l_rd)
    );
    gjinv_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_work (
        .aclk(aclk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd)
    );
    gjinv_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_comp (
        .aclk(aclk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd)
    );
    gjinv_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));
    gjinv_mac u_mac (
        .aclk(aclk), .a_in(mac_a), .f_in(fac_reg), .b_in(mac_b), .res(mac_res)
    );

    assign init_cnt = {1'b0, r_reg, c_reg};
    assign nm1 = IDX_W'(n_reg - 4'd1);
    assign w_rd_s = w_rd;
    assign v_rd_s = v_rd;
    assign sel_rd = side_reg ? v_rd_s : w_rd_s;
    assign mag_v = w_rd_s[31] ? 33'(-{w_rd_s[31], w_rd_s}) : {1'b0, w_rd_s};
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EPS) ? {16'h0, eps_reg} : {28'h0, n_reg};
    assign s_ready = (st_reg == ST_LOAD);
    assign l_we = s_valid && s_ready;
    assign m_valid = mv_reg;
    assign m_data = md_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= 4'd8;
            eps_reg <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_SIZE) begin
                n_reg <= (pwdata[3:0] > 4'(MAX_DIM)) ? 4'(MAX_DIM) : pwdata[3:0];
            end else begin
                eps_reg <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        st_next = st_reg;
        ph_next = ph_reg;
        col_next = col_reg;
        r_next = r_reg;
        c_next = c_reg;
        prow_next = prow_reg;
        side_next = side_reg;
        piv_next = piv_reg;
        fac_next = fac_reg;
        t_next = t_reg;
        u_next = u_reg;
        sing_next = sing_reg;
        mv_next = mv_reg;
        md_next = md_reg;
        w_we = 1'b0; w_wa = {r_reg, c_reg}; w_wd = '0; w_ra = {r_reg, c_reg};
        v_we = 1'b0; v_wa = {r_reg, c_reg}; v_wd = '0; v_ra = {r_reg, c_reg};
        l_ra = {r_reg, c_reg};
        dreq.start = 1'b0; dreq.num = sel_rd; dreq.den = piv_reg;
        mac_a = sel_rd; mac_b = t_reg;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        case (st_reg)
            ST_LOAD: begin
                if (s_valid && s_data.last_element && n_reg != 4'd0) begin
                    st_next = ST_INIT;
                    r_next = '0; c_next = '0; ph_next = '0;
                end
            end
            ST_INIT: begin
                // copy loaded matrix into w (through the registered read), identity into v
                if (ph_reg == 3'd0) begin
                    ph_next = 3'd1;
                    prow_next = r_reg; u_next = 32'(c_reg);
                    {r_next, c_next} = ADDR_W'(init_cnt + 1'b1);
                end else begin
                    w_we = 1'b1; w_wa = {prow_reg, u_reg[IDX_W-1:0]}; w_wd = l_rd;
                    v_we = 1'b1; v_wa = {prow_reg, u_reg[IDX_W-1:0]};
                    v_wd = (prow_reg == u_reg[IDX_W-1:0]) ? Q_ONE : 32'h0;
                    l_ra = {r_reg, c_reg};
                    ph_next = 3'd0;
                    if (init_cnt == '0) begin
                        // wrapped through all entries
                        st_next = ST_SCAN; col_next = '0;
                        r_next = '0; ph_next = '0;
                    end
                end
            end
            ST_SCAN: begin
                w_ra = {r_reg, col_reg};
                if (ph_reg == 3'd0) begin
                    ph_next = 3'd1;
                end else begin
                    ph_next = 3'd0;
                    if (mag_v > {17'h0, eps_reg}) begin
                        prow_next = r_reg; st_next = ST_SWAP;
                        c_next = '0; side_next = 1'b0;
                    end else if (r_reg == nm1) begin
                        sing_next = 1'b1; st_next = ST_OUT;
                    end else begin
                        r_next = r_reg + 1'b1;
                    end
                end
            end
            ST_SWAP: begin
                // per element: read pivot row, read col row, write both
                if (prow_reg == col_reg) begin
                    st_next = ST_PIV; ph_next = '0;
                end else begin
                    case (ph_reg)
                        3'd0: begin
                            w_ra = {prow_reg, c_reg}; v_ra = {prow_reg, c_reg};
                            ph_next = 3'd1;
                        end
                        3'd1: begin
                            w_ra = {col_reg, c_reg}; v_ra = {col_reg, c_reg};
                            t_next = w_rd_s; u_next = v_rd_s; ph_next = 3'd2;
                        end
                        default: begin
                            w_we = 1'b1; w_wa = {prow_reg, c_reg}; w_wd = w_rd_s;
                            v_we = 1'b1; v_wa = {prow_reg, c_reg}; v_wd = v_rd_s;
                            ph_next = 3'd3;
                            if (ph_reg == 3'd3) begin
                                w_wa = {col_reg, c_reg}; w_wd = t_reg;
                                v_wa = {col_reg, c_reg}; v_wd = u_reg;
                                ph_next = 3'd0;
                                if (c_reg == nm1) begin
                                    st_next = ST_PIV;
                                end else begin
                                    c_next = c_reg + 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_PIV: begin
                w_ra = {col_reg, col_reg};
                if (ph_reg == 3'd0) begin
                    ph_next = 3'd1;
                end else begin
                    piv_next = w_rd_s; ph_next = '0;
                    c_next = '0; side_next = 1'b0; st_next = ST_DIV;
                end
            end
            ST_DIV: begin
                w_ra = {col_reg, c_reg}; v_ra = {col_reg, c_reg};
                case (ph_reg)
                    3'd0: ph_next = 3'd1;
                    3'd1: begin
                        dreq.start = 1'b1; ph_next = 3'd2;
                    end
                    default: begin
                        if (drsp.done) begin
                            ph_next = 3'd0;
                            if (!side_reg) begin
                                w_we = 1'b1; w_wa = {col_reg, c_reg}; w_wd = drsp.quo;
                                side_next = 1'b1;
                            end else begin
                                v_we = 1'b1; v_wa = {col_reg, c_reg}; v_wd = drsp.quo;
                                side_next = 1'b0;
                                if (c_reg == nm1) begin
                                    st_next = ST_FACT; r_next = '0;
                                end else begin
                                    c_next = c_reg + 1'b1;
                                end
                            end
                        end
                    end
                endcase
            end
            ST_FACT: begin
                w_ra = {r_reg, col_reg};
                if (ph_reg == 3'd0) begin
                    ph_next = 3'd1;
                end else begin
                    ph_next = '0;
                    fac_next = w_rd_s;
                    if (r_reg != col_reg && w_rd_s != 32'h0) begin
                        st_next = ST_ELIM; c_next = '0; side_next = 1'b0;
                    end else if (r_reg == nm1) begin
                        if (col_reg == nm1) begin
                            st_next = ST_OUT; sing_next = 1'b0;
                            r_next = '0; c_next = '0;
                        end else begin
                            col_next = col_reg + 1'b1;
                            r_next = col_reg + 1'b1; st_next = ST_SCAN;
                        end
                    end else begin
                        r_next = r_reg + 1'b1;
                    end
                end
            end
            ST_ELIM: begin
                // phase 0: read pivot-row elem; 1: latch, read target; 2: mult; 3: write
                case (ph_reg)
                    3'd0: begin
                        w_ra = {col_reg, c_reg}; v_ra = {col_reg, c_reg};
                        ph_next = 3'd1;
                    end
                    3'd1: begin
                        t_next = sel_rd;
                        w_ra = {r_reg, c_reg}; v_ra = {r_reg, c_reg};
                        ph_next = 3'd2;
                    end
                    3'd2: begin
                        w_ra = {r_reg, c_reg}; v_ra = {r_reg, c_reg};
                        ph_next = 3'd3;
                    end
                    default: begin
                        w_ra = {r_reg, c_reg}; v_ra = {r_reg, c_reg};
                        ph_next = 3'd0;
                        if (!side_reg) begin
                            w_we = 1'b1; w_wd = mac_res; side_next = 1'b1;
                        end else begin
                            v_we = 1'b1; v_wd = mac_res; side_next = 1'b0;
                            if (c_reg == nm1) begin
                                if (r_reg == nm1) begin
                                    if (col_reg == nm1) begin
                                        st_next = ST_OUT; sing_next = 1'b0;
                                        r_next = '0; c_next = '0;
                                    end else begin
                                        col_next = col_reg + 1'b1;
                                        r_next = col_reg + 1'b1; st_next = ST_SCAN;
                                    end
                                end else begin
                                    r_next = r_reg + 1'b1; st_next = ST_FACT;
                                end
                            end else begin
                                c_next = c_reg + 1'b1;
                            end
                        end
                    end
                endcase
            end
            ST_OUT: begin
                v_ra = {r_reg, c_reg};
                if (!mv_reg || m_ready) begin
                    if (ph_reg == 3'd0) begin
                        ph_next = 3'd1;
                    end else begin
                        ph_next = 3'd0;
                        mv_next = 1'b1;
                        md_next.singular = sing_reg;
                        if (sing_reg) begin
                            md_next.out_row = '0; md_next.out_col = '0;
                            md_next.out_value = '0; md_next.last_result = 1'b1;
                            st_next = ST_WAIT;
                        end else begin
                            md_next.out_row = r_reg; md_next.out_col = c_reg;
                            md_next.out_value = v_rd_s;
                            md_next.last_result = (r_reg == nm1) && (c_reg == nm1);
                            if (c_reg == nm1) begin
                                c_next = '0;
                                if (r_reg == nm1) begin
                                    st_next = ST_WAIT;
                                end else begin
                                    r_next = r_reg + 1'b1;
                                end
                            end else begin
                                c_next = c_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            ST_WAIT: begin
                if (!mv_next) begin
                    st_next = ST_LOAD;
                end
            end
            default: st_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_LOAD;
            ph_reg <= '0;
            mv_reg <= 1'b0;
            side_reg <= 1'b0;
            sing_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            ph_reg <= ph_next;
            mv_reg <= mv_next;
            side_reg <= side_next;
            sing_reg <= sing_next;
        end
        col_reg <= col_next;
        r_reg <= r_next;
        c_reg <= c_next;
        prow_reg <= prow_next;
        piv_reg <= piv_next;
        fac_reg <= fac_next;
        t_reg <= t_next;
        u_reg <= u_next;
        md_reg <= md_next;
    end

    `ASSERT_IMP(a_no_accept_busy, aclk, aresetn, st_reg != ST_LOAD, !s_ready)
    `ASSERT_IMP(a_div_idle_start, aclk, aresetn, dreq.start, !drsp.busy)
    `ASSERT_NEXT(a_out_only_drain, aclk, aresetn, !mv_reg && st_reg != ST_OUT, !mv_reg)

endmodule
